FILE: hdl/multilevel_feedback_scheduler_macros.svh
// assertion helpers for the scheduler engine rtl
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, checked outside reset
`define MFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

FILE: hdl/mfs_pkg.sv
`timescale 1ns / 1ps

package mfs_pkg;

  localparam int ID_W     = 8;
  localparam int WORK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LVLOUT_W = 2;
  localparam int CLOCK_W  = 32;
  localparam int LIU_W    = 3;
  localparam int CFG_W    = 16;
  localparam int CFGA_W   = 2;

  // command queue of the front, ahead of the engine
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = 1;
  localparam int CMDQ_CW    = 2;

  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_ROUND = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RAN    = 2'd0,
    ST_ADMIT  = 2'd1,
    ST_REJECT = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  typedef enum logic [CFGA_W-1:0] {
    CFG_QUANTUM = 2'd0,
    CFG_LEVELS  = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_EMIT
  } eng_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WORK_W-1:0] work;
  } entry_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   task_id;
    logic [WORK_W-1:0] burst;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

FILE: hdl/mfs_cmd_queue.sv
`timescale 1ns / 1ps

// front: takes input beats and holds them until the engine is free
module mfs_cmd_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mfs_pkg::cmd_t            in_cmd,
  output mfs_pkg::cmd_head_t       head,
  input  logic                     pop
);

  mfs_pkg::cmd_t                    slots [mfs_pkg::CMDQ_DEPTH];
  logic [mfs_pkg::CMDQ_PW-1:0]      wr_ptr;
  logic [mfs_pkg::CMDQ_PW-1:0]      rd_ptr;
  logic [mfs_pkg::CMDQ_CW-1:0]      count;
  logic                             push;
  logic                             take;

  assign in_stall = (count == mfs_pkg::CMDQ_CW'(mfs_pkg::CMDQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign take     = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/mfs_engine.sv
`timescale 1ns / 1ps
`include "multilevel_feedback_scheduler_macros.svh"

// back: level fifos in one memory, sweep sequencer and result register
module mfs_engine #(
  parameter int MAX_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mfs_pkg::WORK_W-1:0]     quantum,
  input  logic [mfs_pkg::LIU_W-1:0]      levels_in_use,
  input  mfs_pkg::cmd_head_t             head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mfs_pkg::STATUS_W-1:0]   status,
  output logic [mfs_pkg::ID_W-1:0]       served_id,
  output logic [mfs_pkg::WORK_W-1:0]     ran_for,
  output logic                           finished,
  output logic [mfs_pkg::LVLOUT_W-1:0]   new_level,
  output logic [mfs_pkg::CLOCK_W-1:0]    clock_now,
  output logic                           all_empty,
  output logic                           last
);

  localparam int LW  = $clog2(MAX_LEVELS + 1);
  localparam int LIW = $clog2(MAX_LEVELS);
  localparam int PW  = $clog2(LEVEL_DEPTH);
  localparam int FW  = $clog2(LEVEL_DEPTH + 1);
  localparam int AW  = $clog2(MAX_LEVELS * LEVEL_DEPTH);
  localparam int NW  = (LW > mfs_pkg::LIU_W + 1) ? LW : mfs_pkg::LIU_W + 1;

  mfs_pkg::eng_state_t state, state_next;

  logic [LW-1:0]     lv, lv_next;
  logic              any_slice, any_slice_next;
  logic              is_slice, is_slice_next;
  logic [PW-1:0]     head_ptr [MAX_LEVELS];
  logic [PW-1:0]     head_ptr_next [MAX_LEVELS];
  logic [PW-1:0]     tail_ptr [MAX_LEVELS];
  logic [PW-1:0]     tail_ptr_next [MAX_LEVELS];
  logic [FW-1:0]     fill [MAX_LEVELS];
  logic [FW-1:0]     fill_next [MAX_LEVELS];
  logic [mfs_pkg::CLOCK_W-1:0] elapsed, elapsed_next;

  // result register
  mfs_pkg::status_t              res_status, res_status_next;
  logic [mfs_pkg::ID_W-1:0]      res_id, res_id_next;
  logic [mfs_pkg::WORK_W-1:0]    res_ran, res_ran_next;
  logic                          res_fin, res_fin_next;
  logic [mfs_pkg::LVLOUT_W-1:0]  res_lvl, res_lvl_next;

  // slot memory
  mfs_pkg::entry_t   slots [MAX_LEVELS * LEVEL_DEPTH];
  mfs_pkg::entry_t   rd_entry;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  mfs_pkg::entry_t   mem_wdata;

  logic [NW-1:0]     liu_wide;
  logic [LW-1:0]     nlev;
  logic [mfs_pkg::WORK_W-1:0] q;
  logic [LIW-1:0]    lvi;
  logic [LIW-1:0]    lvn;
  logic              bottom;
  logic              fin;
  logic [mfs_pkg::WORK_W-1:0] ran;
  logic              next_room;
  logic              later_busy;
  logic              none_left;
  logic              admit_ok;
  logic              admit_full;

  function automatic logic [AW-1:0] slot_addr(input logic [LIW-1:0] l, input logic [PW-1:0] p);
    slot_addr = AW'(l) * AW'(LEVEL_DEPTH) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // clamp the active level count into 2..MAX_LEVELS
  always_comb begin
    liu_wide = NW'(levels_in_use);
    if (liu_wide < NW'(2)) begin
      nlev = LW'(2);
    end else if (liu_wide > NW'(MAX_LEVELS)) begin
      nlev = LW'(MAX_LEVELS);
    end else begin
      nlev = LW'(liu_wide);
    end
  end

  assign q         = (quantum == '0) ? mfs_pkg::WORK_W'(1) : quantum;
  assign lvi       = lv[LIW-1:0];
  assign lvn       = LIW'(lv + 1'b1);
  assign bottom    = (lv == nlev - 1'b1);
  assign fin       = bottom || (rd_entry.work <= q);
  assign ran       = fin ? rd_entry.work : q;
  assign next_room = (fill[lvn] != FW'(LEVEL_DEPTH));
  assign admit_ok  = (fill[0] != FW'(LEVEL_DEPTH));
  assign admit_full = (state == mfs_pkg::S_IDLE) && head.valid &&
                      (head.cmd.op == mfs_pkg::OP_ADMIT) && !admit_ok;

  always_comb begin
    later_busy = 1'b0;
    none_left  = 1'b1;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (fill[i] != '0) begin
        none_left = 1'b0;
        if (LW'(i) > lv && LW'(i) < nlev) begin
          later_busy = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mfs_pkg::S_IDLE: begin
        if (head.valid) begin
          if (head.cmd.op == mfs_pkg::OP_ADMIT) begin
            state_next = mfs_pkg::S_EMIT;
          end else begin
            state_next = mfs_pkg::S_SCAN;
          end
        end
      end
      mfs_pkg::S_SCAN: begin
        if (lv == nlev) begin
          if (any_slice) begin
            state_next = mfs_pkg::S_IDLE;
          end else begin
            state_next = mfs_pkg::S_EMIT;
          end
        end else if (fill[lvi] != '0) begin
          state_next = mfs_pkg::S_EXEC;
        end
      end
      mfs_pkg::S_EXEC: begin
        state_next = mfs_pkg::S_EMIT;
      end
      mfs_pkg::S_EMIT: begin
        if (!out_stall) begin
          if (is_slice) begin
            state_next = mfs_pkg::S_SCAN;
          end else begin
            state_next = mfs_pkg::S_IDLE;
          end
        end
      end
      default: state_next = mfs_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      mfs_pkg::S_IDLE: pop       = head.valid;
      mfs_pkg::S_EMIT: out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    lv_next         = lv;
    any_slice_next  = any_slice;
    is_slice_next   = is_slice;
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    fill_next       = fill;
    elapsed_next    = elapsed;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_ran_next    = res_ran;
    res_fin_next    = res_fin;
    res_lvl_next    = res_lvl;
    mem_we          = 1'b0;
    mem_waddr       = slot_addr(lvi, tail_ptr[lvi]);
    mem_wdata       = rd_entry;
    mem_raddr       = slot_addr(lvi, head_ptr[lvi]);

    case (state)
      mfs_pkg::S_IDLE: begin
        if (head.valid) begin
          if (head.cmd.op == mfs_pkg::OP_ADMIT) begin
            if (admit_ok) begin
              mem_we           = 1'b1;
              mem_waddr        = slot_addr('0, tail_ptr[0]);
              mem_wdata.id     = head.cmd.task_id;
              mem_wdata.work   = head.cmd.burst;
              tail_ptr_next[0] = ptr_inc(tail_ptr[0]);
              fill_next[0]     = fill[0] + 1'b1;
              res_status_next  = mfs_pkg::ST_ADMIT;
            end else begin
              res_status_next  = mfs_pkg::ST_REJECT;
            end
            res_id_next     = head.cmd.task_id;
            res_ran_next    = '0;
            res_fin_next    = 1'b0;
            res_lvl_next    = '0;
            is_slice_next   = 1'b0;
          end else begin
            lv_next        = '0;
            any_slice_next = 1'b0;
          end
        end
      end
      mfs_pkg::S_SCAN: begin
        if (lv == nlev) begin
          if (!any_slice) begin
            res_status_next = mfs_pkg::ST_NONE;
            res_id_next     = '0;
            res_ran_next    = '0;
            res_fin_next    = 1'b0;
            res_lvl_next    = '0;
            is_slice_next   = 1'b0;
          end
        end else if (fill[lvi] == '0) begin
          lv_next = lv + 1'b1;
        end else begin
          // head read issued here, data lands in rd_entry
          head_ptr_next[lvi] = ptr_inc(head_ptr[lvi]);
          fill_next[lvi]     = fill[lvi] - 1'b1;
        end
      end
      mfs_pkg::S_EXEC: begin
        elapsed_next    = elapsed + mfs_pkg::CLOCK_W'(ran);
        res_status_next = mfs_pkg::ST_RAN;
        res_id_next     = rd_entry.id;
        res_ran_next    = ran;
        res_fin_next    = fin;
        res_lvl_next    = mfs_pkg::LVLOUT_W'(lv);
        is_slice_next   = 1'b1;
        any_slice_next  = 1'b1;
        mem_wdata.id    = rd_entry.id;
        mem_wdata.work  = rd_entry.work - ran;
        if (!fin) begin
          mem_we = 1'b1;
          if (next_room) begin
            // demote to the next level
            mem_waddr          = slot_addr(lvn, tail_ptr[lvn]);
            tail_ptr_next[lvn] = ptr_inc(tail_ptr[lvn]);
            fill_next[lvn]     = fill[lvn] + 1'b1;
            res_lvl_next       = mfs_pkg::LVLOUT_W'(lv + 1'b1);
          end else begin
            // next level full, back to the tail of this one
            mem_waddr          = slot_addr(lvi, tail_ptr[lvi]);
            tail_ptr_next[lvi] = ptr_inc(tail_ptr[lvi]);
            fill_next[lvi]     = fill_next[lvi] + 1'b1;
          end
        end
      end
      mfs_pkg::S_EMIT: begin
        if (!out_stall && is_slice) begin
          lv_next = lv + 1'b1;
        end
      end
      default: begin
        lv_next = lv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_waddr] <= mem_wdata;
    end
    rd_entry <= slots[mem_raddr];
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_ran    <= res_ran_next;
    res_fin    <= res_fin_next;
    res_lvl    <= res_lvl_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfs_pkg::S_IDLE;
      lv        <= '0;
      any_slice <= 1'b0;
      is_slice  <= 1'b0;
      elapsed   <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_ptr[i] <= '0;
        tail_ptr[i] <= '0;
        fill[i]     <= '0;
      end
    end else begin
      state     <= state_next;
      lv        <= lv_next;
      any_slice <= any_slice_next;
      is_slice  <= is_slice_next;
      elapsed   <= elapsed_next;
      head_ptr  <= head_ptr_next;
      tail_ptr  <= tail_ptr_next;
      fill      <= fill_next;
    end
  end

  assign status    = res_status;
  assign served_id = res_id;
  assign ran_for   = res_ran;
  assign finished  = res_fin;
  assign new_level = res_lvl;
  assign clock_now = elapsed;
  assign all_empty = none_left;
  assign last      = !is_slice || !later_busy;

  // a held result keeps the scheduled time it reports
  `MFS_ASSERT_NEXT(a_hold_clock, out_valid && out_stall, out_valid && $stable(elapsed))
  // a full top level turns an admit into a reject
  `MFS_ASSERT_NEXT(a_reject_full, admit_full, res_status == mfs_pkg::ST_REJECT)
  // the sweep never runs past the active levels
  `MFS_ASSERT_NOW(a_scan_bound, state == mfs_pkg::S_SCAN, lv <= nlev)
  // the scheduled time only moves on an executed slice
  `MFS_ASSERT_NEXT(a_clock_exec, state != mfs_pkg::S_EXEC, $stable(elapsed))

endmodule

FILE: hdl/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps

// multilevel feedback queue scheduler. an admit beat (op 0) puts a task (id,
// remaining work) at the tail of level 0 and gives one result: admitted, or
// rejected when level 0 is full. a round beat (op 1) sweeps the active levels
// top to bottom; each non-empty level runs its head task for the quantum (or
// to completion if the work left fits, and always to completion at the bottom
// level) and gives one result beat; an unfinished task drops to the next
// level, or back into its own level when the next one is full. a round that
// finds nothing gives one "nothing to run" beat. last marks the final beat of
// each input beat. timing: an input beat is held in a two-entry command queue
// while the engine is busy, so input and output stall independently. the
// engine handles one command at a time: an admit takes a decode step and a
// result step; a round takes a decode step, a scan step for each empty active
// level, for each served level a head read from the shared slot memory, an
// execute and write-back step and a result step, then a closing scan step
// and a final result step when nothing ran. the slot memory has one read and
// one write port, which is what serializes the per-level steps. the user must
// ensure configuration is written only while idle; the block does not
// enforce this, and slot contents need no clearing after reset.
module multilevel_feedback_scheduler #(
  parameter int MAX_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [mfs_pkg::CFGA_W-1:0]     cfg_addr,
  input  logic [mfs_pkg::CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [mfs_pkg::ID_W-1:0]       task_id,
  input  logic [mfs_pkg::WORK_W-1:0]     burst,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mfs_pkg::STATUS_W-1:0]   status,
  output logic [mfs_pkg::ID_W-1:0]       served_id,
  output logic [mfs_pkg::WORK_W-1:0]     ran_for,
  output logic                           finished,
  output logic [mfs_pkg::LVLOUT_W-1:0]   new_level,
  output logic [mfs_pkg::CLOCK_W-1:0]    clock_now,
  output logic                           all_empty,
  output logic                           last
);

  logic [mfs_pkg::WORK_W-1:0] quantum;
  logic [mfs_pkg::LIU_W-1:0]  levels_in_use;
  mfs_pkg::cmd_t              in_cmd;
  mfs_pkg::cmd_head_t         cmd_head;
  logic                       cmd_pop;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum       <= mfs_pkg::WORK_W'(3);
      levels_in_use <= mfs_pkg::LIU_W'(3);
    end else if (cfg_we) begin
      case (cfg_addr)
        mfs_pkg::CFG_QUANTUM: quantum       <= cfg_data;
        mfs_pkg::CFG_LEVELS:  levels_in_use <= cfg_data[mfs_pkg::LIU_W-1:0];
        default: begin
          quantum       <= quantum;
          levels_in_use <= levels_in_use;
        end
      endcase
    end
  end

  // input beat packed for the command queue
  assign in_cmd.op      = mfs_pkg::op_t'(op);
  assign in_cmd.task_id = task_id;
  assign in_cmd.burst   = burst;

  // front: command queue
  mfs_cmd_queue u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .head     (cmd_head),
    .pop      (cmd_pop)
  );

  // back: level fifos, sweep and result register
  mfs_engine #(
    .MAX_LEVELS  (MAX_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .quantum       (quantum),
    .levels_in_use (levels_in_use),
    .head          (cmd_head),
    .pop           (cmd_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .served_id     (served_id),
    .ran_for       (ran_for),
    .finished      (finished),
    .new_level     (new_level),
    .clock_now     (clock_now),
    .all_empty     (all_empty),
    .last          (last)
  );

endmodule
